### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/sc2a_pkg.sv
// ---------------------------------------------------------------------------
// sc2a_pkg
// Types, key codes and translation tables for the scan code translator.
// ---------------------------------------------------------------------------
package sc2a_pkg;

   localparam int unsigned CodeWidth  = 8;
   localparam int unsigned CharWidth  = 7;
   localparam int unsigned TableSize  = 84;
   localparam int unsigned IndexWidth = $clog2(TableSize);

   localparam logic [CodeWidth-1:0] CODE_RSHIFT_MAKE  = 8'h36;
   localparam logic [CodeWidth-1:0] CODE_LSHIFT_MAKE  = 8'h2A;
   localparam logic [CodeWidth-1:0] CODE_RSHIFT_BREAK = 8'hB6;
   localparam logic [CodeWidth-1:0] CODE_LSHIFT_BREAK = 8'hAA;
   localparam logic [CodeWidth-1:0] CODE_PREFIX       = 8'hE0;
   localparam logic [CodeWidth-1:0] CODE_CTRL_MAKE    = 8'h1D;
   localparam logic [CodeWidth-1:0] CODE_CTRL_BREAK   = 8'h9D;
   localparam logic [CodeWidth-1:0] CODE_ALT_MAKE     = 8'h38;
   localparam logic [CodeWidth-1:0] CODE_ALT_BREAK    = 8'hB8;
   localparam logic [CodeWidth-1:0] CODE_CAPS_MAKE    = 8'h3A;
   localparam logic [CodeWidth-1:0] CODE_NUM_MAKE     = 8'h45;
   localparam logic [CodeWidth-1:0] CODE_CAPS_BREAK   = 8'hBA;
   localparam logic [CodeWidth-1:0] CODE_NUM_BREAK    = 8'hC5;
   localparam logic [CodeWidth-1:0] CODE_NUMPAD_FIRST = 8'd71;
   localparam logic [CodeWidth-1:0] CODE_TABLE_END    = 8'd84;

   localparam logic [7:0] NO_CHAR   = 8'h80;
   localparam logic [CharWidth-1:0] CTRL_MASK = 7'h1F;

   localparam logic [7:0] PLAIN_MAP [TableSize] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
      8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
      8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
      8'h2C, 8'h2E, 8'h2F, 8'h80,
      8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
   };

   localparam logic [7:0] UPPER_MAP [TableSize] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
      8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
      8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
      8'h3C, 8'h3E, 8'h3F, 8'h80,
      8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
      8'h34, 8'h35, 8'h36, 8'h80,
      8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
   };

   typedef struct packed {
      logic shift_down;
      logic control_down;
      logic num_lock_on;
   } flags_type;

   typedef struct packed {
      logic                 has_char;
      logic [CharWidth-1:0] ascii_char;
      flags_type            flags;
   } decode_type;

endpackage

### hw/rtl/scancode_to_ascii_translator.sv
// ---------------------------------------------------------------------------
// scancode_to_ascii_translator
// Set-1 keyboard scan code to ASCII translation with modifier tracking.
// ---------------------------------------------------------------------------
//
//   channel   direction   tdata bits           tuser / tlast
//   req_      in          [7:0] scan_code      none
//   rsp_      out         [6:0] ascii_char     none
//
// One word per cycle sustained while rsp_ does not stall. A word lands in the
// input register, is decoded in the next cycle by the table lookup and flag
// logic, and the character (if any) then lands in the output register.
// Words that give no character are retired without touching rsp_.
// Reset (synchronous) clears shift, control, num lock and both valid bits.
// A stalled rsp_ holds the decoded word in the input register; req_tready
// only drops when both registers are full and the output is not taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scancode_to_ascii_translator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] ascii_char, [7] zero
);

   // input register
   logic                                s1_valid_ff;
   logic [sc2a_pkg::CodeWidth-1:0]      s1_code_ff;
   // output register
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [sc2a_pkg::CharWidth-1:0]      out_char_ff;

   logic                                s1_advance;
   logic                                req_fire;
   sc2a_pkg::flags_type                 flags;
   sc2a_pkg::decode_type                dec;

   // the decoded word may move on whenever the output register is free
   // or is being emptied this cycle
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_code_ff <= req_tdata;
      end
   end

   sc2a_decode u_decode (
      .scan_code (s1_code_ff),
      .flags     (flags),
      .result    (dec)
   );

   // flags only change when the word that changes them is retired
   sc2a_flags u_flags (
      .clock    (clock),
      .reset    (reset),
      .update   (s1_advance),
      .flags_in (dec.flags),
      .flags    (flags)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (s1_advance) begin
         out_valid_in = dec.has_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && dec.has_char) begin
         out_char_ff <= dec.ascii_char;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};

   `ASSERT_CLK(a_rsp_from_s1, clock, reset, $rose(rsp_tvalid) |-> $past(s1_valid_ff),
      "output became valid without a decoded word")
   `ASSERT_CLK(a_ctrl_mask, clock, reset,
      (s1_advance && dec.has_char && flags.control_down) |=> (rsp_tdata[6:5] == 2'b00),
      "control character not masked to five bits")
   `ASSERT_NEVER(a_ready_stall, clock, reset,
      !req_tready && !(s1_valid_ff && out_valid_ff && !rsp_tready),
      "input stalled while the pipeline could move")

endmodule

### hw/rtl/sc2a_decode.sv
// ---------------------------------------------------------------------------
// sc2a_decode
// Combinational decode of one scan code: modifier update and table lookup.
// ---------------------------------------------------------------------------
module sc2a_decode (
   input  logic [sc2a_pkg::CodeWidth-1:0] scan_code,
   input  sc2a_pkg::flags_type            flags,
   output sc2a_pkg::decode_type           result
);

   logic                              modifier;
   logic                              in_table;
   logic                              use_upper;
   logic [sc2a_pkg::IndexWidth-1:0]   index;
   logic [7:0]                        entry;
   logic                              has_char;
   logic [sc2a_pkg::CharWidth-1:0]    ascii_char;
   sc2a_pkg::flags_type               next_flags;

   always_comb begin
      next_flags = flags;
      modifier   = 1'b1;
      case (scan_code)
         sc2a_pkg::CODE_RSHIFT_MAKE, sc2a_pkg::CODE_LSHIFT_MAKE: begin
            next_flags.shift_down = 1'b1;
         end
         sc2a_pkg::CODE_RSHIFT_BREAK, sc2a_pkg::CODE_LSHIFT_BREAK: begin
            next_flags.shift_down = 1'b0;
         end
         sc2a_pkg::CODE_CTRL_MAKE: begin
            next_flags.control_down = 1'b1;
         end
         sc2a_pkg::CODE_CTRL_BREAK: begin
            next_flags.control_down = 1'b0;
         end
         sc2a_pkg::CODE_NUM_BREAK: begin
            next_flags.num_lock_on = ~flags.num_lock_on;
         end
         // swallowed without any flag change
         sc2a_pkg::CODE_PREFIX, sc2a_pkg::CODE_ALT_MAKE, sc2a_pkg::CODE_ALT_BREAK,
         sc2a_pkg::CODE_CAPS_MAKE, sc2a_pkg::CODE_NUM_MAKE,
         sc2a_pkg::CODE_CAPS_BREAK: begin
            modifier = 1'b1;
         end
         default: begin
            modifier = 1'b0;
         end
      endcase
   end

   assign in_table  = (scan_code < sc2a_pkg::CODE_TABLE_END);
   assign index     = scan_code[sc2a_pkg::IndexWidth-1:0];
   // keypad codes follow num lock first, then shift
   assign use_upper = flags.shift_down |
                      (flags.num_lock_on & (scan_code >= sc2a_pkg::CODE_NUMPAD_FIRST));

   always_comb begin
      if (!in_table) begin
         entry = sc2a_pkg::NO_CHAR;
      end else if (use_upper) begin
         entry = sc2a_pkg::UPPER_MAP[index];
      end else begin
         entry = sc2a_pkg::PLAIN_MAP[index];
      end
   end

   assign has_char   = !modifier && (entry != sc2a_pkg::NO_CHAR);
   assign ascii_char = flags.control_down
                       ? (entry[sc2a_pkg::CharWidth-1:0] & sc2a_pkg::CTRL_MASK)
                       : entry[sc2a_pkg::CharWidth-1:0];

   assign result = {has_char, ascii_char, next_flags};

endmodule

### hw/rtl/sc2a_flags.sv
// ---------------------------------------------------------------------------
// sc2a_flags
// Keyboard modifier state: shift, control and num lock.
// ---------------------------------------------------------------------------
module sc2a_flags (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  sc2a_pkg::flags_type flags_in,
   output sc2a_pkg::flags_type flags
);

   sc2a_pkg::flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (update) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-1 scan code to ASCII translator: a short
// directed pass over modifiers, dropped codes and table edges, then
// keyboard-like random traffic with bursty input and a stalling output.
// ---------------------------------------------------------------------------
module testbench;

   localparam int          RANDOM_ITEMS = 1100;    // words in random part
   localparam int          HOLD_ACTIONS = 40;      // actions offered during long stall
   localparam int          LONG_HOLD    = 300;     // output held off, in cycles
   localparam int          DRAIN_CYCLES = 10;      // slack after the last expected char
   localparam int          CYCLE_LIMIT  = 400000;
   localparam logic [7:0]  KEY_RELEASE  = 8'h80;   // bit 7 marks a break code

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the key flags and lookup tables, expected chars
   // ------------------------------------------------------------------------
   class char_scoreboard;
      logic [7:0] plain_tbl [sc2a_pkg::TableSize];
      logic [7:0] upper_tbl [sc2a_pkg::TableSize];
      logic       shift_down;
      logic       control_down;
      logic       num_lock_on;
      logic [6:0] pending_chars [$];
      int         errors;
      int         chars_checked;

      function new();
         plain_tbl = '{
            8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
            8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
            8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
            8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80,
            8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
            8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
            8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
            8'h2C, 8'h2E, 8'h2F, 8'h80,
            8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
         };
         upper_tbl = '{
            8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
            8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
            8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
            8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80,
            8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
            8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
            8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
            8'h3C, 8'h3E, 8'h3F, 8'h80,
            8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
            8'h34, 8'h35, 8'h36, 8'h80,
            8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
         };
         shift_down    = 1'b0;
         control_down  = 1'b0;
         num_lock_on   = 1'b0;
         errors        = 0;
         chars_checked = 0;
      endfunction

      // Translate one accepted scan code; queue the char if one comes out.
      // Returns 1 when the word changes a flag or gives a char.
      function bit note_code(logic [7:0] code);
         logic [7:0] ch;
         case (code)
            sc2a_pkg::CODE_RSHIFT_MAKE, sc2a_pkg::CODE_LSHIFT_MAKE: begin
               shift_down = 1'b1;
               return 1'b1;
            end
            sc2a_pkg::CODE_RSHIFT_BREAK, sc2a_pkg::CODE_LSHIFT_BREAK: begin
               shift_down = 1'b0;
               return 1'b1;
            end
            sc2a_pkg::CODE_CTRL_MAKE: begin
               control_down = 1'b1;
               return 1'b1;
            end
            sc2a_pkg::CODE_CTRL_BREAK: begin
               control_down = 1'b0;
               return 1'b1;
            end
            sc2a_pkg::CODE_NUM_BREAK: begin
               num_lock_on = !num_lock_on;
               return 1'b1;
            end
            sc2a_pkg::CODE_PREFIX, sc2a_pkg::CODE_ALT_MAKE, sc2a_pkg::CODE_ALT_BREAK,
            sc2a_pkg::CODE_CAPS_MAKE, sc2a_pkg::CODE_NUM_MAKE,
            sc2a_pkg::CODE_CAPS_BREAK: begin
               return 1'b0;
            end
            default: begin
            end
         endcase
         if (code >= sc2a_pkg::CODE_TABLE_END)
            return 1'b0;
         // keypad half follows num lock first, then shift
         if (code >= sc2a_pkg::CODE_NUMPAD_FIRST && num_lock_on)
            ch = upper_tbl[code];
         else
            ch = shift_down ? upper_tbl[code] : plain_tbl[code];
         if (ch == sc2a_pkg::NO_CHAR)
            return 1'b0;
         if (control_down)
            ch = ch & {1'b0, sc2a_pkg::CTRL_MASK};
         pending_chars.push_back(ch[6:0]);
         return 1'b1;
      endfunction

      // Compare one accepted output word with the oldest expected char.
      function void check_char(logic [7:0] word);
         logic [6:0] want;
         if (pending_chars.size() == 0) begin
            errors++;
            $display("%0t ERROR: unexpected char, expected none, actual 0x%02h",
                     $time, word);
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (word !== {1'b0, want}) begin
            errors++;
            $display("%0t ERROR: ascii_char expected 0x%02h, actual 0x%02h",
                     $time, {1'b0, want}, word);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] scan_code
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] ascii_char, [7] zero

   char_scoreboard sb = new();

   int  burst_left   = 0;     // words left in the current input burst
   bit  no_gaps      = 1'b0;  // sender runs flat out while set
   bit  hold_req     = 1'b0;  // asks the output side for its long stall
   int  codes_sent   = 0;
   int  acting_codes = 0;
   int  cycle_count  = 0;

   scancode_to_ascii_translator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // Offer one word, wait for the handshake, then maybe idle between bursts.
   // tvalid stays high across a burst; it only drops when a gap follows.
   task automatic send_code(input logic [7:0] code);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sb.note_code(code))
         acting_codes++;
      codes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (!no_gaps) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // long bursts give stretches with no input idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // One keyboard-like action: mostly key strokes and modifier traffic,
   // some prefixes and ignored keys, plus raw noise over the full byte.
   task automatic send_random_action();
      int         pick;
      logic [7:0] key;
      pick = $urandom_range(0, 99);
      key  = 8'($urandom_range(0, sc2a_pkg::TableSize - 1));
      if (pick < 45) begin
         send_code(key);
         send_code(key | KEY_RELEASE);
      end else if (pick < 55) begin
         if ($urandom_range(0, 1))
            send_code($urandom_range(0, 1) ? sc2a_pkg::CODE_LSHIFT_MAKE
                                           : sc2a_pkg::CODE_RSHIFT_MAKE);
         else
            send_code($urandom_range(0, 1) ? sc2a_pkg::CODE_LSHIFT_BREAK
                                           : sc2a_pkg::CODE_RSHIFT_BREAK);
      end else if (pick < 62) begin
         // break twice as likely so control is up most of the time
         send_code(($urandom_range(0, 2) == 0) ? sc2a_pkg::CODE_CTRL_MAKE
                                               : sc2a_pkg::CODE_CTRL_BREAK);
      end else if (pick < 67) begin
         send_code(sc2a_pkg::CODE_NUM_MAKE);
         send_code(sc2a_pkg::CODE_NUM_BREAK);
      end else if (pick < 72) begin
         send_code(sc2a_pkg::CODE_PREFIX);
         send_code(key);
      end else if (pick < 77) begin
         case ($urandom_range(0, 3))
            0: send_code(sc2a_pkg::CODE_ALT_MAKE);
            1: send_code(sc2a_pkg::CODE_ALT_BREAK);
            2: send_code(sc2a_pkg::CODE_CAPS_MAKE);
            default: send_code(sc2a_pkg::CODE_CAPS_BREAK);
         endcase
      end else if (pick < 90) begin
         send_code(8'($urandom_range(0, 255)));
      end else begin
         send_code(key);
      end
   endtask

   // ------------------------------------------------------------------------
   // Output side: check every accepted word, stall on a pattern of its own
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int mode;
      int mode_left;
      int hold_left;
      int phase;
      bit hold_served;
      mode        = 0;
      mode_left   = 0;
      hold_left   = 0;
      phase       = 0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_char(rsp_tdata);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         phase = (phase == 2) ? 0 : phase + 1;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;                            // never stalls
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);     // mostly stalled
               default: rsp_tready <= (phase == 0);              // ready only in phase zero
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d chars still expected",
               cycle_count, sb.pending_chars.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      logic [7:0] directed [$];
      int         random_start;

      // Table edges, every modifier, dropped codes and the keypad under
      // num lock; flags are left clear at the end of the list.
      directed = '{
         8'h00,                          // scan zero gives char zero
         8'h01,                          // escape
         8'h53,                          // last entry, plain table: DEL
         sc2a_pkg::CODE_LSHIFT_MAKE,
         8'h53,                          // last entry, shifted table: DEL
         8'h10,                          // 'Q'
         sc2a_pkg::CODE_LSHIFT_BREAK,
         sc2a_pkg::CODE_RSHIFT_MAKE,
         8'h02,                          // '!'
         sc2a_pkg::CODE_RSHIFT_BREAK,
         sc2a_pkg::CODE_CTRL_MAKE,
         8'h1E,                          // 'a' masked to 5 bits
         sc2a_pkg::CODE_CTRL_BREAK,
         sc2a_pkg::CODE_PREFIX,
         sc2a_pkg::CODE_ALT_MAKE,
         sc2a_pkg::CODE_ALT_BREAK,
         sc2a_pkg::CODE_CAPS_MAKE,
         sc2a_pkg::CODE_CAPS_BREAK,
         sc2a_pkg::CODE_NUM_MAKE,
         sc2a_pkg::CODE_NUM_BREAK,       // num lock on
         8'h47,                          // keypad '7'
         sc2a_pkg::CODE_NUM_BREAK,       // num lock off
         8'h4B,                          // keypad left arrow: no char
         sc2a_pkg::CODE_TABLE_END,       // first code past the tables
         8'hFF                           // release of nothing known
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_code(directed[i]);

      // Long output stall while the input keeps offering back to back words,
      // so both pipeline registers fill and req_tready drops.
      no_gaps  = 1'b1;
      hold_req <= 1'b1;
      repeat (HOLD_ACTIONS) send_random_action();
      no_gaps  = 1'b0;

      random_start = codes_sent;
      while (codes_sent - random_start < RANDOM_ITEMS)
         send_random_action();

      req_tvalid <= 1'b0;
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d scan code words (%0d acting on flags or chars),",
               codes_sent, acting_codes);
      $display("%0d chars checked, bursty input, patterned and long output stalls",
               sb.chars_checked);
      if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_decode.sv
hw/rtl/sc2a_flags.sv
hw/rtl/scancode_to_ascii_translator.sv
tb/testbench.sv
